FILE: rtl/core/rgbs_pkg.sv
// Shared types and constants for the RDS group block sequencer.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package rgbs_pkg;

    localparam int TEXT_CHARS = 64;
    localparam int PS_CHARS   = 8;
    localparam int MAX_GROUPS = 20;
    localparam int PS_GROUPS  = 4;

    // Text is kept four characters to a row, PS two characters to a row
    localparam int TEXT_ROWS = TEXT_CHARS / 4;
    localparam int RT_ROW_W  = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam int PS_ROWS   = PS_CHARS / 2;
    localparam int PS_ROW_W  = $clog2(PS_ROWS);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PS_WR = 2'd1;
    localparam logic [1:0] OP_RT_WR = 2'd2;

    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_D = 2'd3;

    localparam logic [7:0]  REG_BLOCK_A    = 8'h03;
    localparam logic [7:0]  REG_BLOCK_BCD  = 8'h05;
    localparam logic [15:0] MUSIC_FLAG     = 16'h0008;
    localparam logic [15:0] TYPE_2A        = 16'h2000;
    localparam logic [7:0]  SPACE_CHAR     = 8'h20;
    localparam logic [15:0] PS_C_RESET     = 16'hE0CD;
    localparam logic [4:0]  PTY_RESET      = 5'd16;
    localparam logic [6:0]  TEXT_LEN_RESET = 7'd64;

    typedef enum logic [2:0] {
        CFG_PI_CODE       = 3'd0,
        CFG_PROGRAM_TYPE  = 3'd1,
        CFG_TEXT_LENGTH   = 3'd2,
        CFG_AB_FLAG       = 3'd3,
        CFG_PS_THIRD_WORD = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] pi_code;
        logic [4:0]  program_type;
        logic [6:0]  text_length;
        logic        ab_flag;
        logic [15:0] ps_third_word;
    } t_cfg;

    typedef struct packed {
        logic       ps_we;
        logic       rt_we;
        logic [5:0] idx;
        logic [7:0] val;
    } t_char_wr;

endpackage

FILE: rtl/core/rgbs_char_store.sv
// Program-service and radiotext character stores, row organized for group reads.
// Depends on rgbs_pkg.
module rgbs_char_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rgbs_pkg::t_char_wr           i_wr,
    input  logic [rgbs_pkg::PS_ROW_W-1:0] i_ps_row,
    input  logic [rgbs_pkg::RT_ROW_W-1:0] i_rt_row,
    output logic [15:0]                  o_ps_pair,
    output logic [31:0]                  o_rt_quad
);

    logic [15:0] r_ps [rgbs_pkg::PS_ROWS];
    logic [31:0] r_rt [rgbs_pkg::TEXT_ROWS];
    logic [5:0]  rt_row_full;
    logic        ps_ok;
    logic        rt_ok;

    // First character of a pair or quad sits in the top byte
    assign rt_row_full = i_wr.idx >> 2;
    assign ps_ok       = i_wr.ps_we && (i_wr.idx < 6'(rgbs_pkg::PS_CHARS));
    assign rt_ok       = i_wr.rt_we && (rt_row_full < 6'(rgbs_pkg::TEXT_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rgbs_pkg::PS_ROWS; k++) begin
                r_ps[k] <= {2{rgbs_pkg::SPACE_CHAR}};
            end
            for (int k = 0; k < rgbs_pkg::TEXT_ROWS; k++) begin
                r_rt[k] <= {4{rgbs_pkg::SPACE_CHAR}};
            end
        end else begin
            if (ps_ok) begin
                r_ps[i_wr.idx[rgbs_pkg::PS_ROW_W:1]][{~i_wr.idx[0], 3'b000} +: 8] <= i_wr.val;
            end
            if (rt_ok) begin
                r_rt[rt_row_full[rgbs_pkg::RT_ROW_W-1:0]][{~i_wr.idx[1:0], 3'b000} +: 8]
                    <= i_wr.val;
            end
        end
    end

    assign o_ps_pair = r_ps[i_ps_row];
    assign o_rt_quad = r_rt[i_rt_row];

endmodule

FILE: rtl/core/rgbs_seq.sv
// Group/block counters, group word latch and output register of the sequencer.
// Depends on rgbs_pkg; reads characters from rgbs_char_store through row addresses.
module rgbs_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  rgbs_pkg::t_cfg                i_cfg,
    input  logic [15:0]                   i_ps_pair,
    input  logic [31:0]                   i_rt_quad,
    input  logic                          i_out_ready,
    output logic [rgbs_pkg::PS_ROW_W-1:0] o_ps_row,
    output logic [rgbs_pkg::RT_ROW_W-1:0] o_rt_row,
    output logic                          o_out_free,
    output logic                          o_valid,
    output logic [15:0]                   o_block_word,
    output logic [1:0]                    o_block_slot,
    output logic [7:0]                    o_target_register,
    output logic [4:0]                    o_group_number
);

    logic [4:0]  r_group, n_group;
    logic [1:0]  r_block, n_block;
    logic [15:0] r_word_b, r_word_c, r_word_d;
    logic [15:0] n_word_b, n_word_c, n_word_d;
    logic        r_out_valid;
    logic [15:0] r_out_word, n_out_word;
    logic [1:0]  r_out_slot;
    logic [7:0]  r_out_target;
    logic [4:0]  r_out_group;

    logic [4:0]  seg;
    logic        is_text;
    logic [4:0]  g_eff;
    logic [15:0] pty_bits;

    always_comb begin
        seg      = r_group - 5'(rgbs_pkg::PS_GROUPS);
        is_text  = (r_group >= 5'(rgbs_pkg::PS_GROUPS))
                   && (seg < 5'(rgbs_pkg::TEXT_ROWS))
                   && ({seg, 2'b00} < i_cfg.text_length);
        // Fall back to the first PS group when the text segment is past the end
        g_eff    = ((r_group >= 5'(rgbs_pkg::PS_GROUPS)) && !is_text) ? 5'd0 : r_group;
        pty_bits = {6'd0, i_cfg.program_type, 5'd0};

        n_word_b   = r_word_b;
        n_word_c   = r_word_c;
        n_word_d   = r_word_d;
        n_out_word = r_word_b;
        n_group    = r_group;
        n_block    = r_block + 2'd1;

        case (r_block)
            rgbs_pkg::SLOT_A: begin
                n_out_word = i_cfg.pi_code;
                n_group    = g_eff;
                if (is_text) begin
                    n_word_b = rgbs_pkg::TYPE_2A | pty_bits
                               | {11'd0, i_cfg.ab_flag, seg[3:0]};
                    n_word_c = i_rt_quad[31:16];
                    n_word_d = i_rt_quad[15:0];
                end else begin
                    n_word_b = pty_bits | rgbs_pkg::MUSIC_FLAG | {14'd0, g_eff[1:0]};
                    n_word_c = i_cfg.ps_third_word;
                    n_word_d = i_ps_pair;
                end
            end
            rgbs_pkg::SLOT_B: n_out_word = r_word_b;
            rgbs_pkg::SLOT_D: begin
                n_out_word = r_word_d;
                n_group    = (r_group == 5'(rgbs_pkg::MAX_GROUPS - 1)) ? 5'd0 : r_group + 5'd1;
            end
            default: n_out_word = r_word_c;
        endcase
    end

    assign o_ps_row   = g_eff[rgbs_pkg::PS_ROW_W-1:0];
    assign o_rt_row   = seg[rgbs_pkg::RT_ROW_W-1:0];
    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group     <= 5'd0;
            r_block     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step) begin
                r_group     <= n_group;
                r_block     <= n_block;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold until the next tick transaction
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_word_b     <= n_word_b;
            r_word_c     <= n_word_c;
            r_word_d     <= n_word_d;
            r_out_word   <= n_out_word;
            r_out_slot   <= r_block;
            r_out_target <= (r_block == rgbs_pkg::SLOT_A) ? rgbs_pkg::REG_BLOCK_A
                                                          : rgbs_pkg::REG_BLOCK_BCD;
            r_out_group  <= n_group;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_block_word      = r_out_word;
    assign o_block_slot      = r_out_slot;
    assign o_target_register = r_out_target;
    assign o_group_number    = r_out_group;

`ifndef NO_ASSERTIONS
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group < 5'(rgbs_pkg::MAX_GROUPS))
        else $error("group counter out of range");

    a_target_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_slot == rgbs_pkg::SLOT_A)
                         == (r_out_target == rgbs_pkg::REG_BLOCK_A)))
        else $error("target register does not match block slot");

    a_wrap_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_block == rgbs_pkg::SLOT_D)) |=> (r_block == rgbs_pkg::SLOT_A))
        else $error("block counter did not wrap after block D");

    a_step_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_out_valid)
        else $error("tick transaction produced no result");

    a_type_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_slot == rgbs_pkg::SLOT_B))
        |-> (r_out_word[13] == (r_out_group >= 5'(rgbs_pkg::PS_GROUPS))))
        else $error("group type bit disagrees with group number");
`endif

endmodule

FILE: rtl/core/rds_group_block_sequencer.sv
// Top level of the RDS group block sequencer: input register, configuration registers,
// character stores and block sequencer. Depends on rgbs_pkg, rgbs_char_store, rgbs_seq.

// One transaction per clock is accepted in steady state; a tick stalls only while the
// result register holds a block word that the receiver has not taken. A tick transaction
// passes through the input register, then the result register, which shows its block word;
// a character write is applied from the input register and returns nothing. The group
// words for A..D are built when block A is sent, so register and character changes
// made during a group appear with the next group. Groups 0..3 are type 0A (PS), then
// type 2A (radiotext) groups follow while the segment start is below text_length.
module rds_group_block_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_char_index,
    input  logic [7:0]  i_char_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_block_word,
    output logic [1:0]  o_block_slot,
    output logic [7:0]  o_target_register,
    output logic [4:0]  o_group_number
);

    rgbs_pkg::t_cfg     r_cfg;
    logic               r_in_valid;
    logic [1:0]         r_in_op;
    logic [5:0]         r_in_idx;
    logic [7:0]         r_in_val;
    logic               advance;
    logic               step;
    logic               out_free;
    rgbs_pkg::t_char_wr char_wr;
    logic [rgbs_pkg::PS_ROW_W-1:0] ps_row;
    logic [rgbs_pkg::RT_ROW_W-1:0] rt_row;
    logic [15:0]        ps_pair;
    logic [31:0]        rt_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pi_code       <= 16'd0;
            r_cfg.program_type  <= rgbs_pkg::PTY_RESET;
            r_cfg.text_length   <= rgbs_pkg::TEXT_LEN_RESET;
            r_cfg.ab_flag       <= 1'b0;
            r_cfg.ps_third_word <= rgbs_pkg::PS_C_RESET;
        end else if (i_cfg_we) begin
            case (rgbs_pkg::t_cfg_reg'(i_cfg_idx))
                rgbs_pkg::CFG_PI_CODE:       r_cfg.pi_code       <= i_cfg_data;
                rgbs_pkg::CFG_PROGRAM_TYPE:  r_cfg.program_type  <= i_cfg_data[4:0];
                rgbs_pkg::CFG_TEXT_LENGTH:   r_cfg.text_length   <= i_cfg_data[6:0];
                rgbs_pkg::CFG_AB_FLAG:       r_cfg.ab_flag       <= i_cfg_data[0];
                rgbs_pkg::CFG_PS_THIRD_WORD: r_cfg.ps_third_word <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A tick waits only for a free result register; writes drain at once
    assign advance = r_in_valid && ((r_in_op != rgbs_pkg::OP_TICK) || out_free);
    assign step    = advance && (r_in_op == rgbs_pkg::OP_TICK);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        char_wr.ps_we = advance && (r_in_op == rgbs_pkg::OP_PS_WR);
        char_wr.rt_we = advance && (r_in_op == rgbs_pkg::OP_RT_WR);
        char_wr.idx   = r_in_idx;
        char_wr.val   = r_in_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_op  <= i_opcode;
            r_in_idx <= i_char_index;
            r_in_val <= i_char_value;
        end
    end

    rgbs_char_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (char_wr),
        .i_ps_row  (ps_row),
        .i_rt_row  (rt_row),
        .o_ps_pair (ps_pair),
        .o_rt_quad (rt_quad)
    );

    rgbs_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_cfg             (r_cfg),
        .i_ps_pair         (ps_pair),
        .i_rt_quad         (rt_quad),
        .i_out_ready       (i_ready),
        .o_ps_row          (ps_row),
        .o_rt_row          (rt_row),
        .o_out_free        (out_free),
        .o_valid           (o_valid),
        .o_block_word      (o_block_word),
        .o_block_slot      (o_block_slot),
        .o_target_register (o_target_register),
        .o_group_number    (o_group_number)
    );

endmodule
